[rtl/celru_pkg.sv]
`timescale 1ns / 1ps

package celru_pkg;

  // operation codes on the command channel
  localparam logic [1:0] OP_LOG     = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_PULL    = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // item kinds on the response channel
  localparam logic [1:0] ITEM_NONE   = 2'd0;
  localparam logic [1:0] ITEM_HEADER = 2'd1;
  localparam logic [1:0] ITEM_RECORD = 2'd2;

  // one stored dose record, 57 bits
  typedef struct packed {
    logic        kind;
    logic [7:0]  dose;
    logic [15:0] glucose;
    logic [31:0] stamp;
  } entry_t;

  // one response item
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [6:0]  header_count;
    logic        rec_kind;
    logic [7:0]  rec_dose;
    logic [15:0] rec_glucose;
    logic [31:0] rec_time;
    logic        session_done;
    logic [6:0]  pending_count;
    logic [31:0] elapsed_a;
    logic [31:0] elapsed_b;
  } result_t;

endpackage

[rtl/celru_cmd_if.sv]
`timescale 1ns / 1ps

interface celru_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] glucose;
  logic        insulin_kind;
  logic [7:0]  dose;
  logic [31:0] stamp;
  logic [31:0] now;
  logic [7:0]  request_count;

  modport source (
    output valid, op, glucose, insulin_kind, dose, stamp, now, request_count,
    input  ready
  );

  modport sink (
    input  valid, op, glucose, insulin_kind, dose, stamp, now, request_count,
    output ready
  );
endinterface

[rtl/celru_rsp_if.sv]
`timescale 1ns / 1ps

interface celru_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [6:0]  header_count;
  logic        rec_kind;
  logic [7:0]  rec_dose;
  logic [15:0] rec_glucose;
  logic [31:0] rec_time;
  logic        session_done;
  logic [6:0]  pending_count;
  logic [31:0] elapsed_a;
  logic [31:0] elapsed_b;

  modport source (
    output valid, item_kind, header_count, rec_kind, rec_dose, rec_glucose, rec_time,
           session_done, pending_count, elapsed_a, elapsed_b,
    input  ready
  );

  modport sink (
    input  valid, item_kind, header_count, rec_kind, rec_dose, rec_glucose, rec_time,
           session_done, pending_count, elapsed_a, elapsed_b,
    output ready
  );
endinterface

[rtl/circular_event_log_with_readout_unit.sv]
`timescale 1ns / 1ps
// ring log of dose records with a paced readout session
// the command is latched on transfer and its result registered on execute
// one command at a time, as the record memory is read in the accept cycle and
//   written back or its read data used in the execute cycle
// reset (rst, synchronous): pointers, counts, session and last a/b times go to zero;
//   the record memory is not cleared, entries are undefined until written

module circular_event_log_with_readout_unit #(
  parameter int LOG_DEPTH = 128
) (
  input logic        clk,
  input logic        rst,
  celru_cmd_if.sink  cmd,
  celru_rsp_if.source rsp
);

  localparam int PTR_W = $clog2(LOG_DEPTH);
  localparam int CMP_W = (PTR_W > 8) ? PTR_W : 8;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LOG_DEPTH - 1);

  // two-step sequencer, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  // record memory, one write port and one registered read port
  celru_pkg::entry_t mem [LOG_DEPTH];
  celru_pkg::entry_t rd_data;

  // latched command
  logic [1:0]  op;
  logic [15:0] glucose;
  logic        insulin_kind;
  logic [7:0]  dose;
  logic [31:0] stamp;
  logic [31:0] now;
  logic [7:0]  request_count;

  // log state
  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic [PTR_W-1:0] pending, pending_next;
  logic [7:0]       session_len, session_len_next;
  logic [8:0]       session_pos, session_pos_next;
  logic             session_open, session_open_next;
  logic [31:0]      last_a_time, last_a_time_next;
  logic [31:0]      last_b_time, last_b_time_next;

  // output register
  logic                  out_valid;
  celru_pkg::result_t    out_q;
  celru_pkg::result_t    res;

  logic             cmd_fire;
  logic             exec_go;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic [8:0]       pos_inc;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // a new command is taken whenever the sequencer is idle, even with a result
  // still waiting in the output register
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  // execute only when the output register can take the result
  assign exec_go   = (state == S_EXEC) && (!out_valid || rsp.ready);

  assign wp_inc  = ring_next(write_ptr);
  assign rp_inc  = ring_next(read_ptr);
  assign pos_inc = session_pos + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (cmd_fire) state <= S_EXEC;
        S_EXEC:  if (exec_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // command latch and tail read in the accept cycle
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op            <= cmd.op;
      glucose       <= cmd.glucose;
      insulin_kind  <= cmd.insulin_kind;
      dose          <= cmd.dose;
      stamp         <= cmd.stamp;
      now           <= cmd.now;
      request_count <= cmd.request_count;
      rd_data       <= mem[read_ptr];
    end
  end

  // head write in the execute cycle; never the same cycle as a read
  always_ff @(posedge clk) begin
    if (exec_go && op == celru_pkg::OP_LOG) begin
      mem[write_ptr] <= '{kind: insulin_kind, dose: dose, glucose: glucose, stamp: stamp};
    end
  end

  always_comb begin
    write_ptr_next    = write_ptr;
    read_ptr_next     = read_ptr;
    pending_next      = pending;
    session_len_next  = session_len;
    session_pos_next  = session_pos;
    session_open_next = session_open;
    last_a_time_next  = last_a_time;
    last_b_time_next  = last_b_time;
    res               = '0;

    case (op)
      celru_pkg::OP_LOG: begin
        write_ptr_next = wp_inc;
        // ring wraps onto tail: drop the oldest entry, pending unchanged
        if (wp_inc == read_ptr) begin
          read_ptr_next = rp_inc;
        end else begin
          pending_next = pending + PTR_W'(1);
        end
        if (insulin_kind) begin
          last_b_time_next = stamp;
        end else begin
          last_a_time_next = stamp;
        end
      end
      celru_pkg::OP_REQUEST: begin
        // clamp to what is pending
        if (CMP_W'(request_count) > CMP_W'(pending)) begin
          session_len_next = 8'(pending);
        end else begin
          session_len_next = request_count;
        end
        session_pos_next  = '0;
        session_open_next = 1'b1;
      end
      celru_pkg::OP_PULL: begin
        // pull with no open session returns an item of kind none
        if (session_open) begin
          if (session_pos == 9'd0) begin
            res.item_kind    = celru_pkg::ITEM_HEADER;
            res.header_count = 7'(session_len);
            res.rec_time     = now;
          end else begin
            res.item_kind   = celru_pkg::ITEM_RECORD;
            res.rec_kind    = rd_data.kind;
            res.rec_dose    = rd_data.dose;
            res.rec_glucose = rd_data.glucose;
            res.rec_time    = rd_data.stamp;
            read_ptr_next   = rp_inc;
            if (pending != '0) begin
              pending_next = pending - PTR_W'(1);
            end
          end
          session_pos_next = pos_inc;
          if (pos_inc >= {1'b0, session_len} + 9'd1) begin
            res.session_done  = 1'b1;
            session_open_next = 1'b0;
          end
        end
      end
      celru_pkg::OP_CLEAR: begin
        // last a/b times survive a clear
        write_ptr_next    = '0;
        read_ptr_next     = '0;
        pending_next      = '0;
        session_len_next  = '0;
        session_pos_next  = '0;
        session_open_next = 1'b0;
      end
      default: ;
    endcase

    res.pending_count = 7'(pending_next);
    res.elapsed_a     = now - last_a_time_next;
    res.elapsed_b     = now - last_b_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr    <= '0;
      read_ptr     <= '0;
      pending      <= '0;
      session_len  <= '0;
      session_pos  <= '0;
      session_open <= 1'b0;
      last_a_time  <= '0;
      last_b_time  <= '0;
    end else if (exec_go) begin
      write_ptr    <= write_ptr_next;
      read_ptr     <= read_ptr_next;
      pending      <= pending_next;
      session_len  <= session_len_next;
      session_pos  <= session_pos_next;
      session_open <= session_open_next;
      last_a_time  <= last_a_time_next;
      last_b_time  <= last_b_time_next;
    end
  end

  // output register: filled on execute, emptied on a response transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_q <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.item_kind     = out_q.item_kind;
  assign rsp.header_count  = out_q.header_count;
  assign rsp.rec_kind      = out_q.rec_kind;
  assign rsp.rec_dose      = out_q.rec_dose;
  assign rsp.rec_glucose   = out_q.rec_glucose;
  assign rsp.rec_time      = out_q.rec_time;
  assign rsp.session_done  = out_q.session_done;
  assign rsp.pending_count = out_q.pending_count;
  assign rsp.elapsed_a     = out_q.elapsed_a;
  assign rsp.elapsed_b     = out_q.elapsed_b;

endmodule

[rtl/celru_checker.sv]
`timescale 1ns / 1ps

module celru_checker (
  input logic         clk,
  input logic         rst,
  celru_cmd_if.sink   cmd,
  celru_rsp_if.source rsp
);

  // held response stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.item_kind)
      && $stable(rsp.rec_time) && $stable(rsp.pending_count))
    else $error("response changed while stalled");

  // one command at a time: no back-to-back command transfers
  a_cmd_spacing: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command taken in consecutive cycles");

  // record fields only on record items
  a_rec_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.item_kind != celru_pkg::ITEM_RECORD |->
      rsp.rec_kind == 1'b0 && rsp.rec_dose == 8'd0 && rsp.rec_glucose == 16'd0)
    else $error("record fields set on a non-record item");

  // an empty item carries no time, no header count and no session end
  a_none_item: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.item_kind == celru_pkg::ITEM_NONE |->
      rsp.rec_time == 32'd0 && !rsp.session_done && rsp.header_count == 7'd0)
    else $error("empty item carries data");

endmodule

bind circular_event_log_with_readout_unit celru_checker u_celru_checker (
  .clk (clk),
  .rst (rst),
  .cmd (cmd),
  .rsp (rsp)
);
